FILE: rtl/srl_pkg.sv
`timescale 1ns / 1ps
// shared types and codes of the sorted ready list engine
package srl_pkg;

    // request kinds
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_INSERT = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  item_id;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] item_count;
        logic [3:0] cursor_item;
        logic       cursor_at_end;
        logic [3:0] head_item;
        logic       list_empty;
    } res_t;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_FETCH    = 8'b0000_0100,
        S_WALK     = 8'b0000_1000,
        S_LINK1    = 8'b0001_0000,
        S_LINK2    = 8'b0010_0000,
        S_UNLINK   = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } seq_state_t;

endpackage

FILE: rtl/srl_ram.sv
`timescale 1ns / 1ps
// simple dual port ram, one write and one registered read per cycle
module srl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/srl_seq.sv
`timescale 1ns / 1ps
// list sequencer: link memories, key memory, walk compare and list registers
module srl_seq #(
    parameter int MAX_ITEMS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  srl_pkg::req_t req,
    input  logic          slot_free,
    output logic          idle,
    output logic          done,
    output srl_pkg::res_t res
);

    import srl_pkg::*;

    localparam int NODE_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam logic [NODE_W-1:0] END_NODE = NODE_W'(MAX_ITEMS);

    seq_state_t state_reg, state_next;

    logic [NODE_W-1:0]    head_reg, head_next;
    logic [NODE_W-1:0]    cursor_reg, cursor_next;
    logic [NODE_W-1:0]    count_reg, count_next;
    logic [MAX_ITEMS-1:0] member_reg, member_next;
    logic [1:0]           status_reg, status_next;

    // request and walk registers, no reset needed
    logic [1:0]        type_reg, type_next;
    logic [NODE_W-1:0] id_reg, id_next;
    logic              bad_reg, bad_next;
    logic [31:0]       value_reg, value_next;
    logic [NODE_W-1:0] at_reg, at_next;
    logic [NODE_W-1:0] nx_reg, nx_next;

    // memory ports
    logic              nl_we, pl_we, key_we;
    logic [IDX_W-1:0]  nl_waddr, pl_waddr, nl_raddr, pl_raddr, key_raddr;
    logic [NODE_W-1:0] nl_wdata, pl_wdata, nl_rdata, pl_rdata;
    logic [31:0]       key_rdata;

    logic [NODE_W+3:0] id_wide;
    logic [IDX_W-1:0]  id_idx;
    logic              member_hit;
    logic [NODE_W+4:0] cnt_wide;
    logic [NODE_W+3:0] cur_wide, head_wide;

    srl_ram #(.DEPTH(MAX_ITEMS), .WIDTH(NODE_W)) u_next_ram (
        .clk   (clk),
        .we    (nl_we),
        .waddr (nl_waddr),
        .wdata (nl_wdata),
        .raddr (nl_raddr),
        .rdata (nl_rdata)
    );

    srl_ram #(.DEPTH(MAX_ITEMS), .WIDTH(NODE_W)) u_prev_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    srl_ram #(.DEPTH(MAX_ITEMS), .WIDTH(32)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (id_idx),
        .wdata (value_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    assign id_wide    = {{NODE_W{1'b0}}, req.item_id};
    assign id_idx     = id_reg[IDX_W-1:0];
    assign member_hit = member_reg[id_idx];

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        member_next = member_reg;
        status_next = status_reg;
        type_next   = type_reg;
        id_next     = id_reg;
        bad_next    = bad_reg;
        value_next  = value_reg;
        at_next     = at_reg;
        nx_next     = nx_reg;
        nl_we       = 1'b0;
        pl_we       = 1'b0;
        key_we      = 1'b0;
        nl_waddr    = '0;
        pl_waddr    = '0;
        nl_wdata    = '0;
        pl_wdata    = '0;
        nl_raddr    = '0;
        pl_raddr    = '0;
        key_raddr   = '0;
        done        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    type_next  = req.req_type;
                    id_next    = id_wide[NODE_W-1:0];
                    bad_next   = (id_wide >= (NODE_W + 4)'(MAX_ITEMS));
                    value_next = req.item_value;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                state_next  = S_FINISH;
                status_next = ST_OK;
                case (type_reg)
                    REQ_CLEAR:
                    begin
                        member_next = '0;
                        count_next  = '0;
                        head_next   = END_NODE;
                        cursor_next = END_NODE;
                    end
                    REQ_APPEND:
                    begin
                        if (bad_reg)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else if (member_hit)
                        begin
                            status_next = ST_DUP;
                        end
                        else
                        begin
                            at_next = cursor_reg;
                            if (cursor_reg == END_NODE)
                            begin
                                nx_next    = head_reg;
                                state_next = S_LINK1;
                            end
                            else
                            begin
                                nl_raddr   = cursor_reg[IDX_W-1:0];
                                state_next = S_FETCH;
                            end
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (bad_reg)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else if (member_hit)
                        begin
                            status_next = ST_DUP;
                        end
                        else
                        begin
                            at_next = END_NODE;
                            nx_next = head_reg;
                            if (head_reg == END_NODE)
                            begin
                                state_next = S_LINK1;
                            end
                            else
                            begin
                                nl_raddr   = head_reg[IDX_W-1:0];
                                key_raddr  = head_reg[IDX_W-1:0];
                                state_next = S_WALK;
                            end
                        end
                    end
                    default:
                    begin
                        if (bad_reg || !member_hit)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            nl_raddr   = id_idx;
                            pl_raddr   = id_idx;
                            state_next = S_UNLINK;
                        end
                    end
                endcase
            end

            S_FETCH:
            begin
                nx_next    = nl_rdata;
                state_next = S_LINK1;
            end

            // one node per cycle: key and successor of nx arrive together
            S_WALK:
            begin
                if (key_rdata <= value_reg)
                begin
                    at_next = nx_reg;
                    nx_next = nl_rdata;
                    if (nl_rdata == END_NODE)
                    begin
                        state_next = S_LINK1;
                    end
                    else
                    begin
                        nl_raddr  = nl_rdata[IDX_W-1:0];
                        key_raddr = nl_rdata[IDX_W-1:0];
                    end
                end
                else
                begin
                    state_next = S_LINK1;
                end
            end

            S_LINK1:
            begin
                nl_we      = 1'b1;
                nl_waddr   = id_idx;
                nl_wdata   = nx_reg;
                pl_we      = 1'b1;
                pl_waddr   = id_idx;
                pl_wdata   = at_reg;
                key_we     = 1'b1;
                state_next = S_LINK2;
            end

            S_LINK2:
            begin
                if (at_reg == END_NODE)
                begin
                    head_next = id_reg;
                end
                else
                begin
                    nl_we    = 1'b1;
                    nl_waddr = at_reg[IDX_W-1:0];
                    nl_wdata = id_reg;
                end
                if (nx_reg != END_NODE)
                begin
                    pl_we    = 1'b1;
                    pl_waddr = nx_reg[IDX_W-1:0];
                    pl_wdata = id_reg;
                end
                member_next[id_idx] = 1'b1;
                count_next          = count_reg + NODE_W'(1);
                if (type_reg == REQ_APPEND)
                begin
                    cursor_next = id_reg;
                end
                state_next = S_FINISH;
            end

            S_UNLINK:
            begin
                if (nl_rdata != END_NODE)
                begin
                    pl_we    = 1'b1;
                    pl_waddr = nl_rdata[IDX_W-1:0];
                    pl_wdata = pl_rdata;
                end
                if (pl_rdata == END_NODE)
                begin
                    head_next = nl_rdata;
                end
                else
                begin
                    nl_we    = 1'b1;
                    nl_waddr = pl_rdata[IDX_W-1:0];
                    nl_wdata = nl_rdata;
                end
                if (cursor_reg == id_reg)
                begin
                    cursor_next = pl_rdata;
                end
                member_next[id_idx] = 1'b0;
                count_next          = count_reg - NODE_W'(1);
                state_next          = S_FINISH;
            end

            S_FINISH:
            begin
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= END_NODE;
            cursor_reg <= END_NODE;
            count_reg  <= '0;
            member_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            member_reg <= member_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        id_reg    <= id_next;
        bad_reg   <= bad_next;
        value_reg <= value_next;
        at_reg    <= at_next;
        nx_reg    <= nx_next;
    end

    // result fields, low bits where the node index is wider than the field
    assign cnt_wide  = {5'b0, count_reg};
    assign cur_wide  = {4'b0, cursor_reg};
    assign head_wide = {4'b0, head_reg};

    always_comb
    begin
        res.status        = status_reg;
        res.item_count    = cnt_wide[4:0];
        res.cursor_at_end = (cursor_reg == END_NODE);
        res.cursor_item   = res.cursor_at_end ? 4'd0 : cur_wide[3:0];
        res.list_empty    = (count_reg == '0);
        res.head_item     = res.list_empty ? 4'd0 : head_wide[3:0];
    end

    assign idle = (state_reg == S_IDLE);

endmodule

FILE: rtl/sorted_ready_list_engine.sv
`timescale 1ns / 1ps
// top level of the sorted ready list engine with result register
//
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+------------------------------------------
// request   | req_valid | req_stall | req_type, item_id, item_value
// result    | res_valid | res_stall | status, item_count, cursor_item,
//           |           |           | cursor_at_end, head_item, list_empty
//
// one request at a time; clear and refused requests pass dispatch and finish,
// append adds fetch unless the cursor is at the end, then link1 and link2,
// remove adds unlink, sorted insert the walk (single key compare) and both links
// reset leaves the list empty and the cursor at the end, no clearing pass
// a stalled result sits in the result register while the next request is taken
module sorted_ready_list_engine #(
    parameter int MAX_ITEMS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  item_id,
    input  logic [31:0] item_value,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [4:0]  item_count,
    output logic [3:0]  cursor_item,
    output logic        cursor_at_end,
    output logic [3:0]  head_item,
    output logic        list_empty
);

    import srl_pkg::*;

    logic  seq_idle;
    logic  seq_done;
    logic  slot_free;
    logic  accept;
    req_t  req;
    res_t  seq_res;

    logic  res_valid_reg, res_valid_next;
    res_t  res_reg;

    // only one request in flight; the sequencer owns the list until it finishes
    assign req_stall = !seq_idle;
    assign accept    = req_valid && !req_stall;

    assign req.req_type   = req_type;
    assign req.item_id    = item_id;
    assign req.item_value = item_value;

    // the result register is free when empty or being taken this cycle
    assign slot_free = !res_valid_reg || !res_stall;

    srl_seq #(.MAX_ITEMS(MAX_ITEMS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .req       (req),
        .slot_free (slot_free),
        .idle      (seq_idle),
        .done      (seq_done),
        .res       (seq_res)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (seq_done)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, loaded only when the slot is free
    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            res_reg <= seq_res;
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = res_reg.status;
    assign item_count    = res_reg.item_count;
    assign cursor_item   = res_reg.cursor_item;
    assign cursor_at_end = res_reg.cursor_at_end;
    assign head_item     = res_reg.head_item;
    assign list_empty    = res_reg.list_empty;

    // an accepted request keeps the request side stalled until it completes
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall
    ) else $error("request side not stalled after accept");

    // an empty list can only leave the cursor on the end node
    a_empty_cursor: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && list_empty) |-> cursor_at_end
    ) else $error("empty list with cursor off the end node");

    // only the three defined status codes are produced
    a_status_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> (status == ST_OK || status == ST_DUP || status == ST_ABSENT)
    ) else $error("undefined status code");

endmodule
